// ===== rtl/fir_icl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_icl_pkg: shared types and constants
// Marker words, default sizes, sideband bundle and adder tree sizing helpers
// for the FIR filter with in-band coefficient load.
// ----------------------------------------------------------------------------
package fir_icl_pkg;

  localparam int TAPS_DEF        = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int COEF_BITS_DEF   = 32;
  localparam int WORD_W          = 32;
  localparam int SUM_W           = 32;

  localparam logic [WORD_W-1:0] WORD_START_LOAD = 32'h0000_BEEF;
  localparam logic [WORD_W-1:0] WORD_END_LOAD   = 32'h0000_ABBA;

  // sideband that rides along with a beat
  typedef struct packed {
    logic       last;
    logic [3:0] keep;
    logic [3:0] strb;
    logic       ident;
    logic       route;
    logic       usr;
  } side_t;

  // number of 4:1 reduction stages needed for n leaves
  function automatic int tree_stages(input int n);
    int s;
    int c;
    s = 0;
    c = 1;
    while (c < n) begin
      c = c * 4;
      s = s + 1;
    end
    if (s == 0) begin
      s = 1;
    end
    return s;
  endfunction

  // leaves padded up to a power of four
  function automatic int tree_leaves(input int n);
    int c;
    int s;
    c = 1;
    for (s = 0; s < tree_stages(n); s++) begin
      c = c * 4;
    end
    return c;
  endfunction

endpackage

// ===== rtl/fir_icl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_icl_front: mode control, tap storage and product stage
// Decodes markers, loads coefficients, shifts the sample history and
// registers all tap products of a filtered beat at the edge that accepts it.
// ----------------------------------------------------------------------------
module fir_icl_front #(
  parameter int TAPS        = fir_icl_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fir_icl_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = fir_icl_pkg::COEF_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    in_word_i,
  input  fir_icl_pkg::side_t    in_side_i,
  input  logic                  tree_rdy_i,
  output logic                  prod_valid_o,
  output fir_icl_pkg::side_t    prod_side_o,
  output logic [31:0]           prod_o [fir_icl_pkg::tree_leaves(TAPS)]
);
  import fir_icl_pkg::*;

  localparam int Leaves = tree_leaves(TAPS);
  localparam int LiW    = $clog2(TAPS + 1);
  localparam int IdxW   = (TAPS > 1) ? $clog2(TAPS) : 1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_LOAD = 3'b010,
    MODE_FILT = 3'b100
  } mode_e;

  mode_e                          mode_q, mode_d;
  logic [LiW-1:0]                 load_idx_q, load_idx_d;
  logic signed [COEF_BITS-1:0]    coef_q [TAPS];
  logic signed [SAMPLE_BITS-1:0]  hist_q [TAPS];
  logic signed [SAMPLE_BITS-1:0]  hist_new [TAPS];
  logic [SUM_W-1:0]               prod_c [Leaves];
  logic [SUM_W-1:0]               prod_q [Leaves];
  logic                           prod_valid_q;
  side_t                          side_q;

  logic rdy;
  logic accept;
  logic is_start;
  logic is_end;
  logic coef_we;
  logic filt;

  assign rdy        = !prod_valid_q || tree_rdy_i;
  assign accept     = in_valid_i && rdy;
  assign in_stall_o = !rdy;

  assign is_start = ($unsigned(in_word_i) == WORD_START_LOAD);
  assign is_end   = ($unsigned(in_word_i) == WORD_END_LOAD);

  always_comb begin
    mode_d     = mode_q;
    load_idx_d = load_idx_q;
    coef_we    = 1'b0;
    filt       = 1'b0;
    unique case (mode_q)
      MODE_LOAD: begin
        if (is_end) begin
          mode_d     = MODE_FILT;
          load_idx_d = '0;
        end else if (load_idx_q < LiW'(TAPS)) begin
          coef_we    = 1'b1;
          load_idx_d = load_idx_q + 1'b1;
        end
      end
      MODE_FILT: begin
        // start marker is filtered before loading begins
        filt = 1'b1;
        if (is_start) begin
          mode_d     = MODE_LOAD;
          load_idx_d = '0;
        end
      end
      MODE_IDLE: begin
        if (is_start) begin
          mode_d     = MODE_LOAD;
          load_idx_d = '0;
        end
      end
      default: begin
        mode_d     = MODE_IDLE;
        load_idx_d = '0;
      end
    endcase
    if (in_side_i.last) begin
      mode_d     = MODE_IDLE;
      load_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      load_idx_q <= '0;
    end else if (accept) begin
      mode_q     <= mode_d;
      load_idx_q <= load_idx_d;
    end
  end

  // history as it stands after this beat is shifted in
  assign hist_new[0] = in_word_i[SAMPLE_BITS-1:0];
  for (genvar k = 1; k < TAPS; k++) begin : g_hist
    assign hist_new[k] = hist_q[k-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        hist_q[k] <= '0;
      end
    end else if (accept && filt) begin
      for (int k = 0; k < TAPS; k++) begin
        hist_q[k] <= hist_new[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        coef_q[k] <= '0;
      end
    end else if (accept && coef_we) begin
      coef_q[load_idx_q[IdxW-1:0]] <= in_word_i[COEF_BITS-1:0];
    end
  end

  // one multiplier per tap, low 32 bits kept; padding leaves read zero
  for (genvar i = 0; i < Leaves; i++) begin : g_prod
    if (i < TAPS) begin : g_tap
      logic signed [SUM_W-1:0] hx;
      logic signed [SUM_W-1:0] cx;
      assign hx        = SUM_W'(hist_new[i]);
      assign cx        = SUM_W'(coef_q[i]);
      assign prod_c[i] = hx * cx;
    end else begin : g_pad
      assign prod_c[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      for (int i = 0; i < Leaves; i++) begin
        prod_q[i] <= prod_c[i];
      end
      side_q <= in_side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (rdy) begin
      prod_valid_q <= accept && filt;
    end
  end

  assign prod_valid_o = prod_valid_q;
  assign prod_side_o  = side_q;
  assign prod_o       = prod_q;

endmodule

// ===== rtl/fir_icl_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_icl_tree: pipelined adder tree
// Reduces the registered tap products four to one per stage, with a valid
// bit and sideband per stage; the last stage is the output register.
// ----------------------------------------------------------------------------
module fir_icl_tree #(
  parameter int TAPS = fir_icl_pkg::TAPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  fir_icl_pkg::side_t    in_side_i,
  input  logic [31:0]           in_sum_i [fir_icl_pkg::tree_leaves(TAPS)],
  output logic                  rdy_o,
  output logic                  out_valid_o,
  output fir_icl_pkg::side_t    out_side_o,
  output logic [31:0]           out_sum_o,
  input  logic                  out_stall_i
);
  import fir_icl_pkg::*;

  localparam int Leaves = tree_leaves(TAPS);
  localparam int Stages = tree_stages(TAPS);

  logic [SUM_W-1:0] lvl_c [Stages][Leaves];
  logic [SUM_W-1:0] nxt_c [Stages][Leaves];
  logic [SUM_W-1:0] sum_q [Stages][Leaves];
  logic [Stages-1:0] vld_q;
  side_t             side_q [Stages];
  logic [Stages:0]   rdy;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    for (genvar i = 0; i < Leaves; i++) begin : g_elem
      if (s == 0) begin : g_src_in
        assign lvl_c[s][i] = in_sum_i[i];
      end else begin : g_src_reg
        assign lvl_c[s][i] = sum_q[s-1][i];
      end
      if (i < (Leaves >> (2 * (s + 1)))) begin : g_add
        assign nxt_c[s][i] = lvl_c[s][4*i] + lvl_c[s][4*i+1]
                           + lvl_c[s][4*i+2] + lvl_c[s][4*i+3];
      end else begin : g_zero
        assign nxt_c[s][i] = '0;
      end
    end
  end

  // a stage may load when empty or when the one after it moves
  always_comb begin
    rdy[Stages] = !out_stall_i;
    for (int s = Stages - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sum_q[0]  <= nxt_c[0];
      side_q[0] <= in_side_i;
    end
    for (int s = 1; s < Stages; s++) begin
      if (rdy[s]) begin
        sum_q[s]  <= nxt_c[s];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < Stages; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  assign rdy_o       = rdy[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_side_o  = side_q[Stages-1];
  assign out_sum_o   = sum_q[Stages-1][0];

endmodule

// ===== rtl/fir_filter_inband_coef_load_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_inband_coef_load_top: direct-form FIR, in-band coefficient load
// Word stream in, filtered words out; coefficients are loaded between the
// 0xBEEF and 0xABBA markers carried on the same stream.
// ----------------------------------------------------------------------------
// One beat is taken per clock in every mode while in_stall_o is low. A filtered
// beat has all TAPS products formed and registered at the edge that accepts
// it, then runs through a 4:1 adder tree with one register per level, and its
// result leaves from the last tree level. Coefficient, end-marker and idle
// beats give no result; a start marker seen in filter mode is filtered. The
// input stalls only when the pipeline is full behind a stalled output; each
// stage holds one beat, so the block keeps accepting while a result waits.
module fir_filter_inband_coef_load_top #(
  parameter int TAPS        = fir_icl_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fir_icl_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = fir_icl_pkg::COEF_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] in_word_i,
  input  logic               in_last_i,
  input  logic [3:0]         in_keep_i,
  input  logic [3:0]         in_strb_i,
  input  logic               in_ident_i,
  input  logic               in_route_i,
  input  logic               in_usr_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_sum_o,
  output logic               out_last_o,
  output logic [3:0]         out_keep_o,
  output logic [3:0]         out_strb_o,
  output logic               out_ident_o,
  output logic               out_route_o,
  output logic               out_usr_o
);
  import fir_icl_pkg::*;

  localparam int Leaves = tree_leaves(TAPS);

  side_t            in_side;
  side_t            prod_side;
  side_t            out_side;
  logic             prod_valid;
  logic             tree_rdy;
  logic [SUM_W-1:0] prod [Leaves];
  logic [SUM_W-1:0] out_sum;

  assign in_side.last  = in_last_i;
  assign in_side.keep  = in_keep_i;
  assign in_side.strb  = in_strb_i;
  assign in_side.ident = in_ident_i;
  assign in_side.route = in_route_i;
  assign in_side.usr   = in_usr_i;

  fir_icl_front #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .in_side_i    (in_side),
    .tree_rdy_i   (tree_rdy),
    .prod_valid_o (prod_valid),
    .prod_side_o  (prod_side),
    .prod_o       (prod)
  );

  fir_icl_tree #(
    .TAPS (TAPS)
  ) u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_side_i   (prod_side),
    .in_sum_i    (prod),
    .rdy_o       (tree_rdy),
    .out_valid_o (out_valid_o),
    .out_side_o  (out_side),
    .out_sum_o   (out_sum),
    .out_stall_i (out_stall_i)
  );

  assign out_sum_o   = $signed(out_sum);
  assign out_last_o  = out_side.last;
  assign out_keep_o  = out_side.keep;
  assign out_strb_o  = out_side.strb;
  assign out_ident_o = out_side.ident;
  assign out_route_o = out_side.route;
  assign out_usr_o   = out_side.usr;

endmodule
